### design/stack_with_value_purge_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack with value purge core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_VALUE_PURGE_CORE_ASSERT_SVH
`define STACK_WITH_VALUE_PURGE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWVP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack core assertion failed");

`endif

### design/swvp_pkg.sv
// ----------------------------------------------------------------------------
// Stack with value purge package
// Shared defaults, operation and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package swvp_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam logic [4:0] CAP_RESET = 5'd16;

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic shift_dn;
    logic shift_up;
  } cell_ctl_t;

endpackage

### design/swvp_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// Holds one entry, shifts toward or away from the top, and compares its
// entry against the search key.
// ----------------------------------------------------------------------------
module swvp_cell #(
  parameter int IDX        = 0,
  parameter int WORD_WIDTH = swvp_pkg::WORD_WIDTH_DEF,
  parameter int CW         = 5
) (
  input  logic                  clk,
  input  swvp_pkg::cell_ctl_t   ctl,
  input  logic [CW-1:0]         base_ptr,
  input  logic [WORD_WIDTH-1:0] prev_data,
  input  logic [WORD_WIDTH-1:0] next_data,
  input  logic [WORD_WIDTH-1:0] key,
  output logic [WORD_WIDTH-1:0] data,
  output logic                  match
);

  logic [WORD_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift_dn) begin
      data_r <= prev_data;
    end else if (ctl.shift_up && (CW'(IDX) >= base_ptr)) begin
      data_r <= next_data;
    end
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

### design/stack_with_value_purge_core.sv
// ----------------------------------------------------------------------------
// Stack with value purge core
// Bounded LIFO stack held in a chain of cells, top in the first cell, with
// push, pop, clear and an order-keeping removal of all matching entries.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       start / busy           in_func, in_operand_value
//  out      out_valid (strobe)     popped_value, removed_count, depth_now, status
//  cfg      cfg_valid / cfg_ready  cfg_data (capacity limit)
//
// For push, pop and clear the result strobes in the cycle after acceptance.
// Remove-matching scans the chain one entry per cycle: after acceptance busy
// stays high until the scan ends, and the result strobes in the same cycle
// that busy falls. An empty stack answers a remove without a scan, with the
// result strobing in the cycle after acceptance.
// Reset is synchronous and active low; it empties the stack and sets the
// capacity limit to 16. The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "stack_with_value_purge_core_assert.svh"

module stack_with_value_purge_core #(
  parameter int DEPTH      = swvp_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = swvp_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  output logic signed [31:0] out_popped_value,
  output logic [4:0]         out_removed_count,
  output logic [4:0]         out_depth_now,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);
  localparam int XW = (CW > 5) ? CW : 5;

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         removed_r, removed_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic [4:0]            cap_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_popped_r, out_popped_nxt;
  logic [4:0]            out_removed_r, out_removed_nxt;
  logic [4:0]            out_depth_r, out_depth_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  swvp_pkg::cell_ctl_t   ctl;
  logic [CW-1:0]         base_ptr;
  logic [WORD_WIDTH-1:0] in_key;
  logic [WORD_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      match;
  logic                  accept;
  logic                  full;

  assign in_key = WORD_WIDTH'($unsigned(in_operand_value));
  assign accept = start && (state_r == IDLE);
  assign full   = (XW'(count_r) >= XW'(cap_r)) || (count_r >= CW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] prev_d;
    logic [WORD_WIDTH-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = in_key;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end
    swvp_cell #(
      .IDX        (i),
      .WORD_WIDTH (WORD_WIDTH),
      .CW         (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .base_ptr  (base_ptr),
      .prev_data (prev_d),
      .next_data (next_d),
      .key       (key_r),
      .data      (cell_data[i]),
      .match     (match[i])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ptr_nxt         = ptr_r;
    removed_nxt     = removed_r;
    key_nxt         = key_r;
    ctl             = '0;
    base_ptr        = '0;
    out_valid_nxt   = 1'b0;
    out_popped_nxt  = out_popped_r;
    out_removed_nxt = out_removed_r;
    out_depth_nxt   = out_depth_r;
    out_status_nxt  = out_status_r;
    case (state_r)
      IDLE: begin
        if (start) begin
          out_popped_nxt  = '0;
          out_removed_nxt = '0;
          out_status_nxt  = swvp_pkg::STATUS_OK;
          out_valid_nxt   = 1'b1;
          case (in_func)
            swvp_pkg::FUNC_PUSH: begin
              if (full) begin
                out_status_nxt = swvp_pkg::STATUS_FULL;
              end else begin
                ctl.shift_dn = 1'b1;
                count_nxt    = count_r + 1'b1;
              end
            end
            swvp_pkg::FUNC_POP: begin
              if (count_r == '0) begin
                out_status_nxt = swvp_pkg::STATUS_EMPTY;
              end else begin
                ctl.shift_up   = 1'b1;
                out_popped_nxt = 32'(cell_data[0]);
                count_nxt      = count_r - 1'b1;
              end
            end
            swvp_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              if (count_r == '0) begin
                out_status_nxt = swvp_pkg::STATUS_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                key_nxt       = in_key;
                ptr_nxt       = '0;
                removed_nxt   = '0;
                state_nxt     = SCAN;
              end
            end
          endcase
          out_depth_nxt = 5'(count_nxt);
        end
      end
      SCAN: begin
        if (ptr_r == count_r) begin
          out_valid_nxt   = 1'b1;
          out_popped_nxt  = '0;
          out_removed_nxt = 5'(removed_r);
          out_depth_nxt   = 5'(count_r);
          out_status_nxt  = swvp_pkg::STATUS_OK;
          state_nxt       = IDLE;
        end else if (match[ptr_r[PW-1:0]]) begin
          ctl.shift_up = 1'b1;
          base_ptr     = ptr_r;
          count_nxt    = count_r - 1'b1;
          removed_nxt  = removed_r + 1'b1;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      cap_r       <= swvp_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
    ptr_r         <= ptr_nxt;
    removed_r     <= removed_nxt;
    key_r         <= key_nxt;
    out_popped_r  <= out_popped_nxt;
    out_removed_r <= out_removed_nxt;
    out_depth_r   <= out_depth_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign busy              = (state_r != IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_popped_value  = out_popped_r;
  assign out_removed_count = out_removed_r;
  assign out_depth_now     = out_depth_r;
  assign out_status        = out_status_r;

  `SWVP_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `SWVP_ASSERT_SAME(a_ptr_bound, state_r == SCAN, ptr_r <= count_r)
  `SWVP_ASSERT_NEXT(a_push_grows, accept && in_func == swvp_pkg::FUNC_PUSH && !full,
    count_r == CW'($past(count_r) + 1'b1))
  `SWVP_ASSERT_NEXT(a_scan_done, state_r == SCAN && ptr_r == count_r,
    out_valid && state_r == IDLE)

endmodule
